// ----- rtl/bfdh_pkg.sv -----
package bfdh_pkg;

    localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME_LO = 64'h1B3;
    localparam int          FNV_PRIME_SH = 40;

    localparam int HASH_W      = 64;
    localparam int DIGIT_BITS  = 4;
    localparam int DIGIT_STEPS = HASH_W / DIGIT_BITS;
    localparam int DCNT_W      = $clog2(DIGIT_STEPS);

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int PCNT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 1'b1;

    localparam logic [CFG_W-1:0]  FILTER_BITS_RST = 17'd65536;
    localparam logic [PCNT_W-1:0] PROBE_COUNT_RST = 5'd7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ACCESS,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic fold;
        logic start;
        logic step_div;
        logic mem_wr;
        logic mem_rd;
        logic check;
        logic next_probe;
        logic out_load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic probes_done;
        logic clr_done;
        logic out_free;
        logic kind;
    } t_status;

endpackage

// ----- rtl/bloom_filter_double_hash.sv -----
// Key bytes: one item per cycle while idle, each valid byte folded into the
// FNV-1a hash register. Last item of a key: per probe a radix-16 remainder,
// digit by digit, plus one store write (insert) or a read and a check (query);
// then the result register is loaded once the output slot is free.
// Reset: synchronous, active low; the bit store is then cleared one bit a
// cycle, every bit of it, with no item accepted until done.
module bloom_filter_double_hash #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_kind,
    input  logic [7:0]                     i_key_byte,
    input  logic                           i_byte_valid,
    input  logic                           i_last_byte,
    input  logic [bfdh_pkg::HASH_W-1:0]    i_first_hash,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_was_query,
    output logic                           o_maybe_present,
    input  logic                           i_cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfdh_pkg::CFG_W-1:0]     i_cfg_data
);
    import bfdh_pkg::*;

    t_cmd    cmd;
    t_status status;

    bfdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last_byte(i_last_byte),
        .i_status   (status),
        .o_ready    (o_ready),
        .o_cmd      (cmd)
    );

    bfdh_datapath #(
        .MAX_BITS  (MAX_BITS),
        .MAX_PROBES(MAX_PROBES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_kind         (i_kind),
        .i_key_byte     (i_key_byte),
        .i_byte_valid   (i_byte_valid),
        .i_first_hash   (i_first_hash),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_was_query    (o_was_query),
        .o_maybe_present(o_maybe_present)
    );
endmodule

// ----- rtl/bfdh_ram.sv -----
module bfdh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/bfdh_ctrl.sv -----
module bfdh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last_byte,
    input  bfdh_pkg::t_status i_status,
    output logic             o_ready,
    output bfdh_pkg::t_cmd   o_cmd
);
    import bfdh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_last_byte) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_DIV;
                    end else begin
                        o_cmd.fold = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.step_div = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (i_status.kind) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_CHECK;
                end else begin
                    o_cmd.mem_wr = 1'b1;
                    if (i_status.probes_done) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.next_probe = 1'b1;
                        n_state          = ST_DIV;
                    end
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_status.probes_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.next_probe = 1'b1;
                    n_state          = ST_DIV;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/bfdh_datapath.sv -----
module bfdh_datapath #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bfdh_pkg::t_cmd                 i_cmd,
    output bfdh_pkg::t_status              o_status,
    input  logic                           i_kind,
    input  logic [7:0]                     i_key_byte,
    input  logic                           i_byte_valid,
    input  logic [bfdh_pkg::HASH_W-1:0]    i_first_hash,
    input  logic                           i_cfg_we,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfdh_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic                           o_was_query,
    output logic                           o_maybe_present
);
    import bfdh_pkg::*;

    localparam int AW = $clog2(MAX_BITS);
    localparam int MW = $clog2(MAX_BITS + 1);
    localparam int KW = $clog2(MAX_PROBES + 1);

    logic [CFG_W-1:0]  r_filter_bits;
    logic [PCNT_W-1:0] r_probe_count;
    logic [HASH_W-1:0] r_fnv, r_h2, r_sum, r_shift;
    logic [MW-1:0]     r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [KW-1:0]     r_pidx;
    logic [AW-1:0]     r_clr;
    logic              r_kind, r_all_set;
    logic              r_ovalid, r_oquery, r_opresent;

    logic [MW-1:0]     m_eff;
    logic [KW-1:0]     k_eff;
    logic [HASH_W-1:0] fnv_x, fnv_next, sum_next;
    logic [MW:0]       rem_t;
    logic [MW-1:0]     rem_next;
    logic              ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]     ram_addr;

    always_comb begin
        if (r_filter_bits == '0) begin
            m_eff = MW'(1);
        end else if (32'(r_filter_bits) > MAX_BITS) begin
            m_eff = MW'(MAX_BITS);
        end else begin
            m_eff = MW'(r_filter_bits);
        end
        if (r_probe_count == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_probe_count) > MAX_PROBES) begin
            k_eff = KW'(MAX_PROBES);
        end else begin
            k_eff = KW'(r_probe_count);
        end
    end

    // prime = 2^40 + 0x1B3
    assign fnv_x    = r_fnv ^ {{(HASH_W-8){1'b0}}, i_key_byte};
    assign fnv_next = (fnv_x << FNV_PRIME_SH) + (fnv_x * FNV_PRIME_LO);
    assign sum_next = r_sum + r_h2;

    // one radix-16 digit of the running remainder per cycle
    always_comb begin
        rem_t = {1'b0, r_rem};
        for (int j = 0; j < DIGIT_BITS; j++) begin
            rem_t = {rem_t[MW-1:0], r_shift[HASH_W-1-j]};
            if (rem_t >= {1'b0, m_eff}) begin
                rem_t = rem_t - {1'b0, m_eff};
            end
        end
        rem_next = rem_t[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= FILTER_BITS_RST;
            r_probe_count <= PROBE_COUNT_RST;
            r_fnv         <= FNV_BASIS;
            r_pidx        <= '0;
            r_dcnt        <= '0;
            r_rem         <= '0;
            r_clr         <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FILTER_BITS: r_filter_bits <= i_cfg_data;
                    REG_PROBE_COUNT: r_probe_count <= i_cfg_data[PCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.fold && i_byte_valid) begin
                r_fnv <= fnv_next;
            end
            if (i_cmd.start) begin
                r_fnv  <= FNV_BASIS;
                r_rem  <= '0;
                r_dcnt <= '0;
                r_pidx <= '0;
            end
            if (i_cmd.step_div) begin
                r_rem  <= rem_next;
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            if (i_cmd.next_probe) begin
                r_rem  <= '0;
                r_dcnt <= '0;
                r_pidx <= r_pidx + KW'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
                r_pidx   <= '0;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_h2      <= i_byte_valid ? fnv_next : r_fnv;
            r_sum     <= i_first_hash;
            r_shift   <= i_first_hash;
            r_kind    <= i_kind;
            r_all_set <= 1'b1;
        end
        if (i_cmd.step_div) begin
            r_shift <= r_shift << DIGIT_BITS;
        end
        if (i_cmd.next_probe) begin
            r_sum   <= sum_next;
            r_shift <= sum_next;
        end
        if (i_cmd.check) begin
            r_all_set <= r_all_set & ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_oquery   <= r_kind;
            r_opresent <= ~r_kind | r_all_set;
        end
    end

    assign ram_we    = i_cmd.clr_step | i_cmd.mem_wr;
    assign ram_wdata = i_cmd.mem_wr;
    assign ram_addr  = i_cmd.clr_step ? r_clr : r_rem[AW-1:0];

    bfdh_ram #(
        .WIDTH(1),
        .DEPTH(MAX_BITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_status.div_done    = (r_dcnt == DCNT_W'(DIGIT_STEPS - 1));
    assign o_status.probes_done = (r_pidx == k_eff - KW'(1));
    assign o_status.clr_done    = (r_clr == AW'(MAX_BITS - 1));
    assign o_status.out_free    = ~r_ovalid | i_ready;
    assign o_status.kind        = r_kind;

    assign o_valid         = r_ovalid;
    assign o_was_query     = r_oquery;
    assign o_maybe_present = r_opresent;

`ifndef SYNTH
    a_wr_rd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.mem_wr && i_cmd.mem_rd))
        else $error("store read and write in one cycle");
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || i_ready))
        else $error("result overwrites an item not taken");
    a_pidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pidx < k_eff)
        else $error("probe index past probe count");
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_step |-> !(i_cmd.start || i_cmd.fold))
        else $error("item taken during clear");
`endif
endmodule

// ----- sim/tb_bloom_filter_double_hash.sv -----
module tb_bloom_filter_double_hash;
    import bfdh_pkg::*;

    localparam int          STORE_BITS = 65536;
    localparam int          PROBE_MAX  = 16;
    localparam logic [63:0] PRIME      = 64'd1099511628211;
    localparam int          LIB_KEYS   = 16;
    localparam int          LIB_LEN    = 8;
    localparam int          DRAIN      = 400;
    localparam int          LIMIT      = 5000000;
    localparam logic        KIND_INSERT = 1'b0;
    localparam logic        KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  key_byte;
        logic        byte_valid;
        logic        last_byte;
        logic [63:0] first_hash;
    } t_item;

    typedef struct packed {
        logic was_query;
        logic maybe_present;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_kind;
    logic [7:0]           i_key_byte;
    logic                 i_byte_valid;
    logic                 i_last_byte;
    logic [HASH_W-1:0]    i_first_hash;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_was_query;
    logic                 o_maybe_present;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    bloom_filter_double_hash dut (.*);

    t_item       pending_items[$];
    t_answer     answers_due[$];
    t_item       cur_item;
    bit          filter_bits_tb[STORE_BITS];
    logic [63:0] fnv_tb;
    logic [16:0] bits_cfg;
    logic [4:0]  probes_cfg;
    int          fails;
    int          cycles;
    bit          calm;

    logic [7:0]  lib_bytes[LIB_KEYS][LIB_LEN];
    int          lib_len[LIB_KEYS];
    logic [63:0] lib_hash[LIB_KEYS];
    int          items_pushed;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 10);
    endfunction

    task automatic fold_item(input t_item it);
        logic [63:0] m;
        logic [63:0] sum;
        logic [15:0] pos;
        int          k;
        bit          all_set;
        t_answer     a;
        m = (bits_cfg == 0) ? 64'd1 : (bits_cfg > STORE_BITS ? 64'(STORE_BITS) : 64'(bits_cfg));
        k = (probes_cfg == 0) ? 1 : (probes_cfg > PROBE_MAX ? PROBE_MAX : int'(probes_cfg));
        all_set = 1'b1;
        if (it.byte_valid)
            fnv_tb = (fnv_tb ^ 64'(it.key_byte)) * PRIME;
        if (it.last_byte) begin
            sum = it.first_hash;
            for (int i = 0; i < k; i++) begin
                pos = 16'(sum % m);
                if (it.kind == KIND_INSERT)
                    filter_bits_tb[pos] = 1'b1;
                else if (!filter_bits_tb[pos])
                    all_set = 1'b0;
                sum += fnv_tb;
            end
            fnv_tb = FNV_BASIS;
            a.was_query = it.kind;
            a.maybe_present = (it.kind == KIND_INSERT) || all_set;
            answers_due.push_back(a);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                fold_item(cur_item);
            if (!i_valid || o_ready) begin
                if (pending_items.size() > 0 && !idle_now()) begin
                    cur_item = pending_items.pop_front();
                    i_kind       <= cur_item.kind;
                    i_key_byte   <= cur_item.key_byte;
                    i_byte_valid <= cur_item.byte_valid;
                    i_last_byte  <= cur_item.last_byte;
                    i_first_hash <= cur_item.first_hash;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer a;
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            i_ready <= !idle_now();
            if (i_rst_n && o_valid && i_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result was_query=%0b maybe_present=%0b",
                           o_was_query, o_maybe_present);
                    fails++;
                end else begin
                    a = answers_due.pop_front();
                    if (o_was_query !== a.was_query) begin
                        $error("was_query expected %0b got %0b", a.was_query, o_was_query);
                        fails++;
                    end
                    if (o_maybe_present !== a.maybe_present) begin
                        $error("maybe_present expected %0b got %0b",
                               a.maybe_present, o_maybe_present);
                        fails++;
                    end
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_raw(input logic kind, input logic [7:0] b, input logic bv,
                            input logic last, input logic [63:0] h1);
        t_item it;
        it.kind = kind;
        it.key_byte = b;
        it.byte_valid = bv;
        it.last_byte = last;
        it.first_hash = h1;
        pending_items.push_back(it);
        if (bv || last)
            items_pushed++;
    endtask

    // last byte may carry the final key byte or be a bare terminator
    task automatic push_key(input logic kind, input int len, input logic [63:0] h1,
                            input int lib, input bit noisy);
        int  n;
        bit  tail_byte;
        tail_byte = (len > 0) && $urandom_range(1);
        n = tail_byte ? len - 1 : len;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(9) == 0)
                push_raw(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0,
                         rand64());
            push_raw(1'($urandom_range(1)),
                     (lib >= 0) ? lib_bytes[lib][i] : 8'($urandom_range(255)),
                     1'b1, 1'b0, rand64());
        end
        if (tail_byte)
            push_raw(kind, (lib >= 0) ? lib_bytes[lib][len-1] : 8'($urandom_range(255)),
                     1'b1, 1'b1, h1);
        else
            push_raw(kind, 8'($urandom_range(255)), 1'b0, 1'b1, h1);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || answers_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_FILTER_BITS)
            bits_cfg = val;
        else
            probes_cfg = val[4:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int lib;
        int goal;
        goal = items_pushed + count;
        while (items_pushed < goal) begin
            if ($urandom_range(9) < 6) begin
                lib = $urandom_range(LIB_KEYS - 1);
                push_key(1'($urandom_range(1)), lib_len[lib], lib_hash[lib], lib, 1'b1);
            end else if ($urandom_range(9) == 0) begin
                push_raw(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0,
                         rand64());
            end else begin
                push_key(1'($urandom_range(1)), $urandom_range(LIB_LEN), rand64(), -1,
                         1'b1);
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_kind       = 1'b0;
        i_key_byte   = '0;
        i_byte_valid = 1'b0;
        i_last_byte  = 1'b0;
        i_first_hash = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        fails        = 0;
        cycles       = 0;
        calm         = 1'b0;
        items_pushed = 0;
        fnv_tb       = FNV_BASIS;
        bits_cfg     = 17'd65536;
        probes_cfg   = 5'd7;
        foreach (filter_bits_tb[i])
            filter_bits_tb[i] = 1'b0;
        for (int i = 0; i < LIB_KEYS; i++) begin
            lib_len[i]  = $urandom_range(LIB_LEN);
            lib_hash[i] = rand64();
            for (int j = 0; j < LIB_LEN; j++)
                lib_bytes[i][j] = 8'($urandom_range(255));
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);

        // directed: defaults, empty keys, idle items, field extremes
        push_key(KIND_QUERY, 0, 64'd0, -1, 1'b0);
        push_key(KIND_INSERT, 0, 64'd0, -1, 1'b0);
        push_key(KIND_QUERY, 0, 64'd0, -1, 1'b0);
        push_raw(KIND_QUERY, 8'hFF, 1'b0, 1'b0, '1);
        push_raw(KIND_INSERT, 8'h00, 1'b1, 1'b0, '0);
        push_raw(KIND_INSERT, 8'hFF, 1'b1, 1'b1, '1);
        push_raw(KIND_QUERY, 8'h00, 1'b1, 1'b0, '0);
        push_raw(KIND_QUERY, 8'hFF, 1'b1, 1'b1, '1);
        push_raw(KIND_QUERY, 8'h5A, 1'b1, 1'b1, 64'h8000_0000_0000_0001);
        push_key(KIND_INSERT, 3, 64'hFFFF_FFFF_FFFF_0000, 0, 1'b0);
        push_key(KIND_QUERY, 3, 64'hFFFF_FFFF_FFFF_0000, 0, 1'b0);
        wait_drained();

        write_reg(REG_FILTER_BITS, 17'd0);
        write_reg(REG_PROBE_COUNT, 17'd0);
        push_key(KIND_QUERY, 0, '1, -1, 1'b0);
        push_key(KIND_INSERT, 1, '1, -1, 1'b0);
        push_key(KIND_QUERY, 2, 64'd7, -1, 1'b0);
        wait_drained();

        write_reg(REG_FILTER_BITS, 17'h1FFFF);
        write_reg(REG_PROBE_COUNT, 17'd31);
        random_phase(250);

        calm = 1'b1;
        write_reg(REG_FILTER_BITS, 17'd1);
        write_reg(REG_PROBE_COUNT, 17'd16);
        random_phase(150);
        calm = 1'b0;

        write_reg(REG_FILTER_BITS, 17'd97);
        write_reg(REG_PROBE_COUNT, 17'd1);
        random_phase(300);

        write_reg(REG_FILTER_BITS, 17'd65536);
        write_reg(REG_PROBE_COUNT, 17'd3);
        random_phase(300);

        write_reg(REG_FILTER_BITS, 17'd1000);
        write_reg(REG_PROBE_COUNT, 17'd16);
        random_phase(300);

        write_reg(REG_FILTER_BITS, 17'd40000);
        write_reg(REG_PROBE_COUNT, 17'd5);
        random_phase(330);

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
